[rtl/core/nkro_pkg.sv]
// ----------------------------------------------------------------------------
// nkro_pkg
// Shared constants, command codes and types of the NKRO keyboard report engine.
// ----------------------------------------------------------------------------
package nkro_pkg;

	localparam int LAST_KEY  = 221;
	localparam int KEY_BYTES = 28;
	localparam int KB_W      = $clog2(KEY_BYTES);
	localparam int FRAME_LEN = KEY_BYTES + 2;
	localparam int POS_W     = $clog2(FRAME_LEN);
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [4:0] MOD_PAGE      = 5'b11100;
	localparam logic [7:0] REPORT_ID_RST = 8'h04;

	localparam logic [2:0] CMD_PRESS       = 3'd0;
	localparam logic [2:0] CMD_RELEASE     = 3'd1;
	localparam logic [2:0] CMD_RELEASE_ALL = 3'd2;
	localparam logic [2:0] CMD_QUERY       = 3'd3;
	localparam logic [2:0] CMD_SEND        = 3'd4;
	localparam logic [2:0] CMD_FORCE_SEND  = 3'd5;

	localparam logic [1:0] STATUS_SENT    = 2'd0;
	localparam logic [1:0] STATUS_SAME    = 2'd1;
	localparam logic [1:0] STATUS_REFUSED = 2'd2;

	typedef struct packed {
		logic [2:0]      cmd;
		logic            is_key;
		logic            is_mod;
		logic [KB_W-1:0] byte_idx;
		logic [2:0]      bit_idx;
		logic            xport_ok;
	} op_t;

	typedef logic [KEY_BYTES-1:0][7:0] keymap_t;

endpackage

[rtl/core/nkro_keyboard_report_engine_top.sv]
// ----------------------------------------------------------------------------
// nkro_keyboard_report_engine_top
// NKRO keyboard report engine: key state, change detection and frame output.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one command per transaction: press,
// release, release-all, query, checked send or forced send. Output channel
// (out_valid/out_stall) returns either one status transaction, or the bytes of
// one or two frames (report id, modifier byte, 28 key bytes each), with
// frame_end set on the last transaction caused by the command.
// A status transaction passes the decode register, the queue and the output register.
// Throughput: key commands run at one per cycle while the receiver does not stall,
// through the decode register, a two-entry queue and the execution unit. A send
// occupies the execution unit for a setup step and then one or two frames, one byte
// per cycle from the frame serializer while out_stall is low; the front keeps taking
// commands until the queue fills.
// Reset clears both reports and sets the report id register to 4.
// A stalled receiver holds the output register; the queue then fills and
// in_stall rises. Write cfg_wr_en/cfg_wr_data only while the block is idle.
// ----------------------------------------------------------------------------
module nkro_keyboard_report_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] cmd,
	input  logic [7:0] key_code,
	input  logic       transport_ok,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] report_byte,
	output logic       frame_end,
	output logic       key_now,
	output logic       key_before,
	output logic       any_mod_now,
	output logic       any_mod_before,
	output logic       key_valid,
	output logic [1:0] send_status
);
	import nkro_pkg::*;

	logic [7:0] report_id_q;
	logic       push_valid;
	op_t        push_op;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;
	op_t        head_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_id_q <= REPORT_ID_RST;
		end else if (cfg_wr_en) begin
			report_id_q <= cfg_wr_data;
		end
	end

	nkro_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.key_code     (key_code),
		.transport_ok (transport_ok),
		.push_valid   (push_valid),
		.push_op      (push_op),
		.q_full       (q_full)
	);

	nkro_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.full       (q_full),
		.empty      (q_empty),
		.pop        (q_pop),
		.head_op    (head_op)
	);

	nkro_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.report_id      (report_id_q),
		.q_empty        (q_empty),
		.op             (head_op),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.report_byte    (report_byte),
		.frame_end      (frame_end),
		.key_now        (key_now),
		.key_before     (key_before),
		.any_mod_now    (any_mod_now),
		.any_mod_before (any_mod_before),
		.key_valid      (key_valid),
		.send_status    (send_status)
	);

`ifndef SYNTHESIS
	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> frame_end)
		else $error("status transaction without frame_end");

	a_status_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> report_byte == 8'h00)
		else $error("status transaction carries a report byte");

	a_frame_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> !key_valid && !key_now && !key_before)
		else $error("frame byte carries key status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> send_status != 2'd3)
		else $error("undefined send status");
`endif

endmodule

[rtl/core/nkro_front.sv]
// ----------------------------------------------------------------------------
// nkro_front
// Accepts commands, classifies the key code and registers the decoded operation.
// ----------------------------------------------------------------------------
module nkro_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [2:0]     cmd,
	input  logic [7:0]     key_code,
	input  logic           transport_ok,
	output logic           push_valid,
	output nkro_pkg::op_t  push_op,
	input  logic           q_full
);
	import nkro_pkg::*;

	logic v_s1;
	op_t  op_s1;
	op_t  op_dec;

	always_comb begin
		op_dec.cmd      = cmd;
		op_dec.is_key   = (32'(key_code) <= LAST_KEY) && (32'(key_code[7:3]) < KEY_BYTES);
		op_dec.is_mod   = (key_code[7:3] == MOD_PAGE);
		op_dec.byte_idx = KB_W'(key_code[7:3]);
		op_dec.bit_idx  = key_code[2:0];
		op_dec.xport_ok = transport_ok;
	end

	assign in_stall   = v_s1 && q_full;
	assign push_valid = v_s1;
	assign push_op    = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= op_dec;
		end
	end

endmodule

[rtl/core/nkro_queue.sv]
// ----------------------------------------------------------------------------
// nkro_queue
// Short FIFO of decoded operations between the front and the back.
// ----------------------------------------------------------------------------
module nkro_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  nkro_pkg::op_t  push_op,
	output logic           full,
	output logic           empty,
	input  logic           pop,
	output nkro_pkg::op_t  head_op
);
	import nkro_pkg::*;

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push_valid && !full;
	assign do_pop  = pop && !empty;
	assign head_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

[rtl/core/nkro_back.sv]
// ----------------------------------------------------------------------------
// nkro_back
// Holds the current and sent reports, executes operations and serializes frames.
// ----------------------------------------------------------------------------
module nkro_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     report_id,
	input  logic           q_empty,
	input  nkro_pkg::op_t  op,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           kind,
	output logic [7:0]     report_byte,
	output logic           frame_end,
	output logic           key_now,
	output logic           key_before,
	output logic           any_mod_now,
	output logic           any_mod_before,
	output logic           key_valid,
	output logic [1:0]     send_status
);
	import nkro_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_FRAME = 1'b1;

	logic             state_q;
	logic [7:0]       cur_mods_q;
	logic [7:0]       sent_mods_q;
	keymap_t          cur_keys_q;
	keymap_t          sent_keys_q;
	logic [POS_W-1:0] pos_q;
	logic             final_q;
	logic             tr_on_q;
	logic             commit_q;
	logic [1:0]       status_q;
	logic             amn_q;
	logic             amb_q;

	logic             out_v_q;
	logic             kind_q;
	logic [7:0]       byte_q;
	logic             end_q;
	logic             now_q;
	logic             before_q;
	logic             amn_out_q;
	logic             amb_out_q;
	logic             valid_q;
	logic [1:0]       status_out_q;

	logic             adv;
	logic             start;
	logic             key_cmd;
	logic             key_hit;
	logic             bit_now;
	logic             bit_sent;
	logic             bit_new;
	logic [7:0]       mods_new;
	logic             keys_diff;
	logic             mods_diff;
	logic [7:0]       changed;
	logic             t_on;
	logic             t_off;
	logic [7:0]       fr_mods;
	keymap_t          fr_keys;
	logic [KB_W-1:0]  kidx;
	logic             last_pos;

	logic             emit;
	logic             o_kind;
	logic [7:0]       o_byte;
	logic             o_end;
	logic             o_now;
	logic             o_before;
	logic             o_amn;
	logic             o_amb;
	logic             o_valid;
	logic [1:0]       o_status;

	assign adv      = !out_v_q || !out_stall;
	assign start    = adv && (state_q == ST_IDLE) && !q_empty;
	assign pop      = start;
	assign last_pos = (32'(pos_q) == FRAME_LEN - 1);

	assign key_cmd   = (op.cmd == CMD_PRESS) || (op.cmd == CMD_RELEASE) || (op.cmd == CMD_QUERY);
	assign key_hit   = key_cmd && (op.is_key || op.is_mod);
	assign keys_diff = (cur_keys_q != sent_keys_q);
	assign mods_diff = (cur_mods_q != sent_mods_q);
	assign changed   = cur_mods_q ^ sent_mods_q;
	assign t_on      = (|(changed & cur_mods_q)) && keys_diff;
	assign t_off     = (|(changed & sent_mods_q)) && keys_diff;

	always_comb begin
		bit_now  = op.is_key ? cur_keys_q[op.byte_idx][op.bit_idx] : cur_mods_q[op.bit_idx];
		bit_sent = op.is_key ? sent_keys_q[op.byte_idx][op.bit_idx] : sent_mods_q[op.bit_idx];
		unique case (op.cmd)
			CMD_PRESS:   bit_new = 1'b1;
			CMD_RELEASE: bit_new = 1'b0;
			default:     bit_new = bit_now;
		endcase
		mods_new = cur_mods_q;
		if (op.cmd == CMD_RELEASE_ALL) begin
			mods_new = '0;
		end else if (key_hit && op.is_mod && !op.is_key) begin
			mods_new[op.bit_idx] = bit_new;
		end
	end

	always_comb begin
		fr_mods = (final_q || tr_on_q) ? cur_mods_q : sent_mods_q;
		fr_keys = (final_q || !tr_on_q) ? cur_keys_q : sent_keys_q;
		kidx    = KB_W'(pos_q - POS_W'(2));
	end

	always_comb begin
		emit     = 1'b0;
		o_kind   = 1'b0;
		o_byte   = '0;
		o_end    = 1'b1;
		o_now    = 1'b0;
		o_before = 1'b0;
		o_amn    = |mods_new;
		o_amb    = |sent_mods_q;
		o_valid  = 1'b0;
		o_status = STATUS_SENT;
		if (state_q == ST_FRAME) begin
			emit     = 1'b1;
			o_kind   = 1'b1;
			o_end    = final_q && last_pos;
			o_amn    = amn_q;
			o_amb    = amb_q;
			o_status = status_q;
			if (pos_q == '0) begin
				o_byte = report_id;
			end else if (pos_q == POS_W'(1)) begin
				o_byte = fr_mods;
			end else begin
				o_byte = fr_keys[kidx];
			end
		end else if (!q_empty) begin
			if (key_cmd) begin
				emit = 1'b1;
				if (key_hit) begin
					o_now    = bit_new;
					o_before = bit_sent;
					o_valid  = 1'b1;
				end
			end else if (op.cmd == CMD_SEND) begin
				emit     = !keys_diff && !mods_diff;
				o_status = STATUS_SAME;
			end else if (op.cmd != CMD_FORCE_SEND) begin
				emit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_mods_q  <= '0;
			sent_mods_q <= '0;
			cur_keys_q  <= '0;
			sent_keys_q <= '0;
			out_v_q     <= 1'b0;
			pos_q       <= '0;
			final_q     <= 1'b0;
			tr_on_q     <= 1'b0;
			commit_q    <= 1'b0;
			status_q    <= STATUS_SENT;
			amn_q       <= 1'b0;
			amb_q       <= 1'b0;
		end else if (adv) begin
			out_v_q <= emit;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cur_mods_q <= mods_new;
						if (op.cmd == CMD_RELEASE_ALL) begin
							cur_keys_q <= '0;
						end else if (key_hit && op.is_key) begin
							cur_keys_q[op.byte_idx][op.bit_idx] <= bit_new;
						end
						if (op.cmd == CMD_SEND && (keys_diff || mods_diff)) begin
							state_q  <= ST_FRAME;
							pos_q    <= '0;
							final_q  <= !(t_on || t_off);
							tr_on_q  <= t_on;
							commit_q <= op.xport_ok;
							status_q <= op.xport_ok ? STATUS_SENT : STATUS_REFUSED;
							amn_q    <= |cur_mods_q;
							amb_q    <= op.xport_ok ? (|cur_mods_q) : (|sent_mods_q);
						end else if (op.cmd == CMD_FORCE_SEND) begin
							state_q  <= ST_FRAME;
							pos_q    <= '0;
							final_q  <= 1'b1;
							tr_on_q  <= 1'b0;
							commit_q <= 1'b0;
							status_q <= STATUS_SENT;
							amn_q    <= |cur_mods_q;
							amb_q    <= |sent_mods_q;
						end
					end
				end
				ST_FRAME: begin
					if (!last_pos) begin
						pos_q <= pos_q + 1'b1;
					end else if (!final_q) begin
						pos_q   <= '0;
						final_q <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
						if (commit_q) begin
							sent_mods_q <= cur_mods_q;
							sent_keys_q <= cur_keys_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			kind_q       <= o_kind;
			byte_q       <= o_byte;
			end_q        <= o_end;
			now_q        <= o_now;
			before_q     <= o_before;
			amn_out_q    <= o_amn;
			amb_out_q    <= o_amb;
			valid_q      <= o_valid;
			status_out_q <= o_status;
		end
	end

	assign out_valid      = out_v_q;
	assign kind           = kind_q;
	assign report_byte    = byte_q;
	assign frame_end      = end_q;
	assign key_now        = now_q;
	assign key_before     = before_q;
	assign any_mod_now    = amn_out_q;
	assign any_mod_before = amb_out_q;
	assign key_valid      = valid_q;
	assign send_status    = status_out_q;

endmodule
